// ===== hdl/pdq_pkg.sv =====
// shared types and constants for the packet descriptor deque
// no dependencies; imported by the top level

package pdq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int BYTES_W     = 24;
  localparam int ENTRY_W     = 9;

  localparam logic [1:0] REQ_PUSH_BACK  = 2'd0;
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // one stored descriptor; seq_mark holds the marker in bit 16
  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] size;
    logic [31:0] stream;
    logic [16:0] seq_mark;
    logic [31:0] enq_time;
    logic [31:0] media;
  } slot_t;

endpackage

// ===== hdl/pdq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module pdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/packet_descriptor_deque.sv =====
// top level of the packet descriptor deque
// depends on pdq_pkg and pdq_ram
//
// usage: drive a request on the input ports with start high; it is taken at
// the rising edge where start is high and busy is low. req_type selects push
// at back, push at front or pop from front. the result is shown on the output
// ports for exactly one cycle with done high and cannot be held off.
// each request passes through the accept cycle, in which the slot after
// the head is read from the descriptor ram, and the execute cycle, in which
// the ram is written and the counters and the head register are updated.
// done rises in the cycle after the execute cycle; busy is high only during
// the execute cycle, so a new request can be taken once that cycle is over,
// while the previous result is still on the outputs. the head descriptor
// lives in a register so that a pop needs only one ram read, the one for
// the new head. reset clears the pointers and counters (the queue is empty);
// the ram needs no clearing, since data from unoccupied slots is never shown.

module packet_descriptor_deque (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] packet_handle,
  input  logic [15:0] byte_size,
  input  logic [31:0] stream_id,
  input  logic [15:0] seq_number,
  input  logic        marker,
  input  logic [31:0] enqueue_time,
  input  logic [31:0] media_stamp,
  input  logic [31:0] now,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] out_handle,
  output logic [15:0] out_size,
  output logic [31:0] out_stream,
  output logic [15:0] out_seq,
  output logic        out_marker,
  output logic [31:0] out_media_stamp,
  output logic [23:0] bytes_queued,
  output logic [8:0]  entry_count,
  output logic signed [16:0] head_size,
  output logic signed [16:0] head_seq,
  output logic signed [31:0] head_delay
);

  import pdq_pkg::*;

  state_t state, state_next;

  logic [IDX_W-1:0]   head, head_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [BYTES_W-1:0] byte_total, byte_total_next;
  slot_t              head_slot, head_slot_next;

  logic [1:0]  req_q;
  slot_t       in_slot;
  logic [31:0] now_q;

  // ram ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            rd_slot;
  logic [IDX_W-1:0] head_inc, head_dec, tail_idx;
  logic [SUM_W-1:0] tail_sum;
  logic             is_full, is_empty;

  logic [1:0] status_next;
  slot_t      pop_slot;

  pdq_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_slot),
    .raddr (head_inc),
    .rdata (rd_slot)
  );

  // ring index arithmetic
  always_comb begin
    head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    head_dec = (head == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head - 1'b1;
    tail_sum = SUM_W'(head) + SUM_W'(fill);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail_idx = tail_sum[IDX_W-1:0];
    is_full  = (fill == CNT_W'(QUEUE_DEPTH));
    is_empty = (fill == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    busy            = 1'b0;
    head_next       = head;
    fill_next       = fill;
    byte_total_next = byte_total;
    head_slot_next  = head_slot;
    wr_en           = 1'b0;
    wr_addr         = tail_idx;
    status_next     = STATUS_DONE;
    pop_slot        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        state_next = ST_IDLE;
        case (req_q)
          REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
            if (is_full) begin
              status_next = STATUS_FULL;
            end else begin
              wr_en           = 1'b1;
              fill_next       = fill + 1'b1;
              byte_total_next = byte_total + BYTES_W'(in_slot.size);
              if (req_q == REQ_PUSH_FRONT) begin
                wr_addr        = head_dec;
                head_next      = head_dec;
                head_slot_next = in_slot;
              end else if (is_empty) begin
                head_slot_next = in_slot;
              end
            end
          end
          REQ_POP_FRONT: begin
            if (is_empty) begin
              status_next = STATUS_EMPTY;
            end else begin
              pop_slot        = head_slot;
              head_next       = head_inc;
              fill_next       = fill - 1'b1;
              byte_total_next = byte_total - BYTES_W'(head_slot.size);
              // slot after the head was read during the accept cycle
              head_slot_next  = rd_slot;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill       <= '0;
      byte_total <= '0;
      done       <= 1'b0;
    end else begin
      head       <= head_next;
      fill       <= fill_next;
      byte_total <= byte_total_next;
      done       <= (state == ST_EXEC);
    end
  end

  // input beat capture and head register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_q            <= req_type;
      in_slot.handle   <= packet_handle;
      in_slot.size     <= byte_size;
      in_slot.stream   <= stream_id;
      in_slot.seq_mark <= {marker, seq_number};
      in_slot.enq_time <= enqueue_time;
      in_slot.media    <= media_stamp;
      now_q            <= now;
    end
    head_slot <= head_slot_next;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      status          <= status_next;
      out_handle      <= pop_slot.handle;
      out_size        <= pop_slot.size;
      out_stream      <= pop_slot.stream;
      out_seq         <= pop_slot.seq_mark[15:0];
      out_marker      <= pop_slot.seq_mark[16];
      out_media_stamp <= pop_slot.media;
      bytes_queued    <= byte_total_next;
      entry_count     <= ENTRY_W'(fill_next);
      if (fill_next == '0) begin
        head_size  <= '1;
        head_seq   <= '1;
        head_delay <= '0;
      end else begin
        head_size  <= {1'b0, head_slot_next.size};
        head_seq   <= {1'b0, head_slot_next.seq_mark[15:0]};
        head_delay <= now_q - head_slot_next.enq_time;
      end
    end
  end

endmodule

// ===== bench/pdq_checker.sv =====
// checker for the packet descriptor deque: watches request and result beats,
// keeps its own ring of descriptors and compares every result field
// depends on pdq_pkg
`timescale 1ns / 1ps

module pdq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] packet_handle,
  input  logic [15:0] byte_size,
  input  logic [31:0] stream_id,
  input  logic [15:0] seq_number,
  input  logic        marker,
  input  logic [31:0] enqueue_time,
  input  logic [31:0] media_stamp,
  input  logic [31:0] now,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [31:0] out_handle,
  input  logic [15:0] out_size,
  input  logic [31:0] out_stream,
  input  logic [15:0] out_seq,
  input  logic        out_marker,
  input  logic [31:0] out_media_stamp,
  input  logic [23:0] bytes_queued,
  input  logic [8:0]  entry_count,
  input  logic signed [16:0] head_size,
  input  logic signed [16:0] head_seq,
  input  logic signed [31:0] head_delay,
  output int          fail_count,
  output int          results_pending,
  output int          n_stored,
  output int          n_popped,
  output int          n_dropped,
  output int          n_empty_pops,
  output int          peak_fill
);

  import pdq_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle;
    logic [15:0] size;
    logic [31:0] stream;
    logic [15:0] seq;
    logic        mark;
    logic [31:0] media;
    logic [23:0] bytes;
    logic [8:0]  count;
    logic [16:0] hsize;
    logic [16:0] hseq;
    logic [31:0] hdelay;
  } deque_result_t;

  slot_t         ring [QUEUE_DEPTH];
  int            head_ptr;
  int            fill_cnt;
  logic [23:0]   byte_sum;
  deque_result_t expected_results [$];
  int            n_checked;

  initial begin
    fail_count   = 0;
    n_stored     = 0;
    n_popped     = 0;
    n_dropped    = 0;
    n_empty_pops = 0;
    peak_fill    = 0;
    n_checked    = 0;
    head_ptr     = 0;
    fill_cnt     = 0;
    byte_sum     = '0;
  end

  // one request against the model; returns the result the block must show
  task automatic apply_request(input logic [1:0] req, input slot_t d, input logic [31:0] t_now,
                               output deque_result_t r);
    int slot;
    r = '0;
    r.status = STATUS_DONE;
    case (req)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (fill_cnt >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
          n_dropped++;
        end else begin
          if (req == REQ_PUSH_BACK) begin
            slot = (head_ptr + fill_cnt) % QUEUE_DEPTH;
          end else begin
            head_ptr = (head_ptr + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            slot = head_ptr;
          end
          ring[slot] = d;
          byte_sum = byte_sum + d.size;
          fill_cnt++;
          n_stored++;
          if (fill_cnt > peak_fill) peak_fill = fill_cnt;
        end
      end
      REQ_POP_FRONT: begin
        if (fill_cnt == 0) begin
          r.status = STATUS_EMPTY;
          n_empty_pops++;
        end else begin
          r.handle = ring[head_ptr].handle;
          r.size   = ring[head_ptr].size;
          r.stream = ring[head_ptr].stream;
          r.seq    = ring[head_ptr].seq_mark[15:0];
          r.mark   = ring[head_ptr].seq_mark[16];
          r.media  = ring[head_ptr].media;
          byte_sum = byte_sum - ring[head_ptr].size;
          fill_cnt--;
          head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
          n_popped++;
        end
      end
      default: ;  // unused code leaves the state alone
    endcase
    r.bytes = byte_sum;
    r.count = ENTRY_W'(fill_cnt);
    if (fill_cnt == 0) begin
      r.hsize  = '1;
      r.hseq   = '1;
      r.hdelay = '0;
    end else begin
      r.hsize  = {1'b0, ring[head_ptr].size};
      r.hseq   = {1'b0, ring[head_ptr].seq_mark[15:0]};
      r.hdelay = t_now - ring[head_ptr].enq_time;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (fail_count < 10)
        $display("result %0d: %s expected %h, got %h", n_checked, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    slot_t         d;
    if (rst) begin
      head_ptr = 0;
      fill_cnt = 0;
      byte_sum = '0;
      expected_results.delete();
    end else begin
      // result beat first: it always belongs to an earlier request
      if (done) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          got  = '{status, out_handle, out_size, out_stream, out_seq, out_marker,
                   out_media_stamp, bytes_queued, entry_count, head_size, head_seq,
                   head_delay};
          check_field("status",          want.status, got.status);
          check_field("out_handle",      want.handle, got.handle);
          check_field("out_size",        want.size,   got.size);
          check_field("out_stream",      want.stream, got.stream);
          check_field("out_seq",         want.seq,    got.seq);
          check_field("out_marker",      want.mark,   got.mark);
          check_field("out_media_stamp", want.media,  got.media);
          check_field("bytes_queued",    want.bytes,  got.bytes);
          check_field("entry_count",     want.count,  got.count);
          check_field("head_size",       want.hsize,  got.hsize);
          check_field("head_seq",        want.hseq,   got.hseq);
          check_field("head_delay",      want.hdelay, got.hdelay);
          n_checked++;
        end
      end
      if (start && !busy) begin
        d.handle   = packet_handle;
        d.size     = byte_size;
        d.stream   = stream_id;
        d.seq_mark = {marker, seq_number};
        d.enq_time = enqueue_time;
        d.media    = media_stamp;
        apply_request(req_type, d, now, want);
        expected_results.insert(expected_results.size(), want);
      end
    end
    results_pending <= expected_results.size();
  end

endmodule

// ===== bench/tb_packet_descriptor_deque.sv =====
// testbench top for the packet descriptor deque: clock, reset, request beats
// and the verdict; result checking lives in pdq_checker
// depends on pdq_pkg, packet_descriptor_deque and pdq_checker
`timescale 1ns / 1ps

module tb_packet_descriptor_deque;
  import pdq_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 100000;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [31:0] packet_handle;
  logic [15:0] byte_size;
  logic [31:0] stream_id;
  logic [15:0] seq_number;
  logic        marker;
  logic [31:0] enqueue_time;
  logic [31:0] media_stamp;
  logic [31:0] now;
  logic        done;
  logic [1:0]  status;
  logic [31:0] out_handle;
  logic [15:0] out_size;
  logic [31:0] out_stream;
  logic [15:0] out_seq;
  logic        out_marker;
  logic [31:0] out_media_stamp;
  logic [23:0] bytes_queued;
  logic [8:0]  entry_count;
  logic signed [16:0] head_size;
  logic signed [16:0] head_seq;
  logic signed [31:0] head_delay;

  int fail_count;
  int results_pending;
  int n_stored;
  int n_popped;
  int n_dropped;
  int n_empty_pops;
  int peak_fill;
  int cycle_count = 0;
  int n_requests  = 0;
  logic [31:0] tick = 32'hFFFF_F000;  // wraps early in the run

  packet_descriptor_deque u_dut (.*);
  pdq_checker u_chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one request beat and hold it until the block takes it
  task automatic send_req(input logic [1:0] req, input logic [31:0] handle,
                          input logic [15:0] size, input logic [31:0] stream,
                          input logic [15:0] seq, input logic mk,
                          input logic [31:0] enq, input logic [31:0] t_now);
    start         <= 1'b1;
    req_type      <= req;
    packet_handle <= handle;
    byte_size     <= size;
    stream_id     <= stream;
    seq_number    <= seq;
    marker        <= mk;
    enqueue_time  <= enq;
    media_stamp   <= $urandom;
    now           <= t_now;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_requests++;
  endtask

  task automatic idle_gap(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // random request; push_pct biases toward filling or draining
  task automatic rand_req(input int push_pct, output bit counted);
    int          r;
    logic [1:0]  req;
    logic [15:0] sz;
    logic [31:0] enq;
    logic [31:0] t_now;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 3) begin
      req = REQ_UNUSED;
      counted = 1'b0;
    end else if (r < 3 + push_pct) begin
      req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    end else begin
      req = REQ_POP_FRONT;
    end
    case ($urandom_range(0, 9))
      0:       sz = 16'h0000;
      1:       sz = 16'hFFFF;
      default: sz = 16'($urandom_range(0, 65535));
    endcase
    tick = tick + $urandom_range(0, 40);
    if ($urandom_range(0, 9) == 0) begin
      enq   = $urandom;
      t_now = $urandom;
    end else begin
      enq   = tick;
      t_now = tick;
    end
    send_req(req, $urandom, sz, $urandom, 16'($urandom_range(0, 65535)),
             1'($urandom_range(0, 1)), enq, t_now);
  endtask

  initial begin
    int phase_pct [5] = '{95, 50, 5, 50, 95};
    int phase_len [5] = '{330, 200, 330, 200, 290};
    int n;
    bit counted;

    rst           <= 1'b1;
    start         <= 1'b0;
    req_type      <= REQ_PUSH_BACK;
    packet_handle <= '0;
    byte_size     <= '0;
    stream_id     <= '0;
    seq_number    <= '0;
    marker        <= 1'b0;
    enqueue_time  <= '0;
    media_stamp   <= '0;
    now           <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, field extremes, front push wrapping the head
    send_req(REQ_POP_FRONT, '1, '1, '1, '1, 1'b1, '1, '1);
    send_req(REQ_UNUSED, '0, '0, '0, '0, 1'b0, '0, '0);
    send_req(REQ_PUSH_BACK, '1, '1, '1, '1, 1'b1, '1, '0);
    idle_gap(1'b1);
    send_req(REQ_PUSH_FRONT, '0, '0, '0, '0, 1'b0, '0, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_BACK, 32'hA5A5_5A5A, 16'h8001, 32'h1234_5678, 16'h8000, 1'b1,
             32'h8000_0000, 32'h8000_0000);
    send_req(REQ_UNUSED, '1, '1, '1, '1, 1'b1, '1, 32'h8000_0000);
    send_req(REQ_POP_FRONT, '0, '0, '0, '0, 1'b0, '0, 32'h0000_0001);
    idle_gap(1'b1);
    send_req(REQ_POP_FRONT, '0, '0, '0, '0, 1'b0, '0, 32'h7FFF_FFFF);
    send_req(REQ_POP_FRONT, '0, '0, '0, '0, 1'b0, '0, 32'h8000_0000);
    send_req(REQ_POP_FRONT, '0, '0, '0, '0, 1'b0, '0, '1);
    send_req(REQ_PUSH_FRONT, 32'h0000_0001, 16'h0001, 32'h8000_0000, 16'hFFFF, 1'b0,
             32'h0000_0010, 32'h0000_0000);
    send_req(REQ_PUSH_FRONT, 32'h8000_0000, 16'h7FFF, 32'h0000_0001, 16'h0001, 1'b1,
             32'h0000_0000, 32'h8000_0000);
    send_req(REQ_POP_FRONT, '0, '0, '0, '0, 1'b0, '0, 32'h8000_0000);
    send_req(REQ_POP_FRONT, '0, '0, '0, '0, 1'b0, '0, '0);

    // random: fill past full, churn, drain past empty, churn, fill again
    for (int p = 0; p < 5; p++) begin
      if (p == 2) wait_drained();
      n = 0;
      while (n < phase_len[p]) begin
        rand_req(phase_pct[p], counted);
        if (counted) n++;
        idle_gap(p != 1);  // no idling through the first churn phase
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);

    $display("%0d requests: %0d descriptors stored, %0d popped, %0d pushes dropped full,",
             n_requests, n_stored, n_popped, n_dropped);
    $display("%0d pops on empty, peak occupancy %0d of %0d", n_empty_pops, peak_fill,
             QUEUE_DEPTH);
    if (fail_count == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, results_pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
